// ===== sv/sams_pkg.sv =====
// ----------------------------------------------------------------------------
// sams_pkg
// shared types, codes and reset values of the stepper axis move sequencer
// ----------------------------------------------------------------------------
package sams_pkg;

  // command codes
  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_GOTO  = 3'd1;
  localparam logic [2:0] CMD_RAW   = 3'd2;
  localparam logic [2:0] CMD_CAL   = 3'd3;
  localparam logic [2:0] CMD_ABORT = 3'd4;

  // result status codes
  localparam logic [2:0] STAT_STEP     = 3'd0;
  localparam logic [2:0] STAT_IDLE     = 3'd1;
  localparam logic [2:0] STAT_ACCEPTED = 3'd2;
  localparam logic [2:0] STAT_THERE    = 3'd3;
  localparam logic [2:0] STAT_UNKNOWN  = 3'd4;
  localparam logic [2:0] STAT_RANGE    = 3'd5;
  localparam logic [2:0] STAT_ABORTED  = 3'd6;

  // configuration register indexes
  localparam logic [2:0] REG_POS_MIN  = 3'd0;
  localparam logic [2:0] REG_POS_MAX  = 3'd1;
  localparam logic [2:0] REG_HOME     = 3'd2;
  localparam logic [2:0] REG_INIT_PER = 3'd3;
  localparam logic [2:0] REG_NORM_PER = 3'd4;
  localparam logic [2:0] REG_SWAP     = 3'd5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 30;
  localparam int POS_W      = 15;
  localparam int TIMING_W   = 30;
  localparam int SEG_W      = 17;

  localparam int MAX_STEPS_DEF = 8192;

  // fixed driver overhead removed from the step timing
  localparam logic [TIMING_W-1:0] TIMING_OFFSET = 30'd70000;

  localparam logic signed [POS_W-1:0] POS_MIN_RST = 15'sd0;
  localparam logic signed [POS_W-1:0] POS_MAX_RST = 15'sd1028;
  localparam logic signed [POS_W-1:0] HOME_RST    = 15'sd514;
  localparam logic [TIMING_W-1:0] INIT_BASE_RST   = 30'd6930000;
  localparam logic [TIMING_W-1:0] NORM_BASE_RST   = 30'd14930000;
  localparam logic SWAP_RST = 1'b1;

  // move sequence phase
  typedef enum logic [4:0] {
    SEQ_RAW  = 5'b00001,
    SEQ_GOTO = 5'b00010,
    SEQ_UP   = 5'b00100,
    SEQ_DOWN = 5'b01000,
    SEQ_RET  = 5'b10000
  } seq_phase_t;

  // decoded move segment
  typedef struct packed {
    logic             empty;
    logic             too_long;
    logic             dir;
    logic [SEG_W-1:0] mag;
  } seg_t;

endpackage

// ===== sv/stepper_axis_move_sequencer.sv =====
// ----------------------------------------------------------------------------
// stepper_axis_move_sequencer
// one stepper axis: move commands in, one PWM step setting per tick out
// ----------------------------------------------------------------------------
// usage:
//   in_* channel takes one command beat (tick, goto, raw steps, calibrate,
//   abort); out_* channel returns exactly one result beat per command beat.
//   a valid/stall handshake is used on both sides: a beat moves at a clock
//   edge where valid is high and stall is low.
//   cfg_* is a plain write port (index, data, write enable); the user must
//   write it only while the block holds no beat; this is not enforced.
// pipeline and throughput:
//   a beat is taken into an input register and processed into the output
//   register. one beat per cycle is sustained while out_stall is low; the
//   combinational step arithmetic and the axis state update lie between
//   the two registers.
// stall:
//   the input register keeps taking beats while the output register is
//   free or being emptied; with out_stall high both registers hold and
//   in_stall rises once the input register is full.
// reset:
//   synchronous, active low; clears the axis state (position unknown, no
//   move) and loads the register defaults. no clearing pass is needed.
// ----------------------------------------------------------------------------
module stepper_axis_move_sequencer
  import sams_pkg::*;
#(
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_wdata,
  // command channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  in_cmd,
  input  logic signed [POS_W-1:0]     in_target_position,
  input  logic signed [POS_W-1:0]     in_step_count,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  out_status,
  output logic [31:0]                 out_period_ns,
  output logic [30:0]                 out_duty_ns,
  output logic [31:0]                 out_phase_a_ns,
  output logic [31:0]                 out_phase_b_ns,
  output logic [31:0]                 out_phase_c_ns,
  output logic [31:0]                 out_phase_d_ns,
  output logic [3:0]                  out_stop_mask,
  output logic                        out_last_step,
  output logic signed [POS_W-1:0]     out_position_now,
  output logic                        out_position_valid
);

  localparam int STEP_W = $clog2(MAX_STEPS + 1);

  // --------------------------------------------------------------------------
  // segment decode: magnitude, direction and length check of a signed count
  // --------------------------------------------------------------------------
  function automatic seg_t seg_info(input logic [15:0] n);
    logic [SEG_W-1:0] nx;
    logic [SEG_W-1:0] neg;
    seg_t             s;
    nx         = {n[15], n};
    neg        = -nx;
    s.mag      = n[15] ? neg : nx;
    s.empty    = (n == '0);
    s.too_long = (s.mag > SEG_W'(MAX_STEPS));
    s.dir      = !n[15] && !s.empty;
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // configuration registers; timing is stored with the offset already removed
  // --------------------------------------------------------------------------
  logic signed [POS_W-1:0] pos_min_r, pos_max_r, home_r;
  logic [TIMING_W-1:0]     base_init_r, base_norm_r;
  logic                    swap_r;
  logic [TIMING_W-1:0]     cfg_base;

  assign cfg_base = (cfg_wdata > TIMING_OFFSET) ? (cfg_wdata - TIMING_OFFSET) : '0;

  // --------------------------------------------------------------------------
  // input register
  // --------------------------------------------------------------------------
  logic                    in_vld_r;
  logic [2:0]              in_cmd_r;
  logic signed [POS_W-1:0] in_tgt_r, in_cnt_r;
  logic                    adv;
  logic                    in_take;
  logic                    out_vld_r;

  // the input beat moves on when the output register is free or emptying
  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;
  assign in_take  = in_valid && !in_stall;

  // --------------------------------------------------------------------------
  // axis state
  // --------------------------------------------------------------------------
  logic signed [POS_W-1:0] pos_r, pend_r, rest_r;
  logic                    known_r, active_r, dir_r;
  logic [STEP_W-1:0]       sidx_r, stot_r;
  seq_phase_t              seq_r;

  logic signed [POS_W-1:0] pos_nxt, pend_nxt, rest_nxt;
  logic                    known_nxt, active_nxt, dir_nxt;
  logic [STEP_W-1:0]       sidx_nxt, stot_nxt;
  seq_phase_t              seq_nxt, seq_mid;
  logic [2:0]              stat_nxt;
  logic                    emit, do_fin, fin_cal, go_ret;
  seg_t                    ret_v;

  // candidate segments
  logic signed [POS_W-1:0] cal_rest;
  seg_t                    seg_goto, seg_raw, seg_cal, seg_dn, seg_ret_r, seg_ret_c;

  assign cal_rest  = known_r ? pos_r : home_r;
  assign seg_goto  = seg_info({pos_r[POS_W-1], pos_r} - {in_tgt_r[POS_W-1], in_tgt_r});
  assign seg_raw   = seg_info({in_cnt_r[POS_W-1], in_cnt_r});
  assign seg_cal   = seg_info({pos_max_r[POS_W-1], pos_max_r} - {pos_min_r[POS_W-1], pos_min_r});
  assign seg_dn    = seg_info({pos_min_r[POS_W-1], pos_min_r} - {pos_max_r[POS_W-1], pos_max_r});
  assign seg_ret_r = seg_info({pos_max_r[POS_W-1], pos_max_r} - {rest_r[POS_W-1], rest_r});
  assign seg_ret_c = seg_info({pos_max_r[POS_W-1], pos_max_r} - {cal_rest[POS_W-1], cal_rest});

  // --------------------------------------------------------------------------
  // step timing of the current step
  // --------------------------------------------------------------------------
  logic [STEP_W:0]     s_ext, t_ext;
  logic                terminal, ramp4, ramp2;
  logic [TIMING_W-1:0] base_sel;
  logic [31:0]         per;
  logic [29:0]         q;
  logic [30:0]         duty, q2;
  logic [31:0]         q3;
  logic [1:0]          half_rem;
  logic                late_stop;
  logic [31:0]         ph [4];

  assign s_ext    = {1'b0, sidx_r};
  assign t_ext    = {1'b0, stot_r};
  assign terminal = (s_ext + (STEP_W+1)'(1)) == t_ext;
  // x4 on the two outer steps at each end, x2 on the first four steps and the last five
  assign ramp4    = (s_ext < (STEP_W+1)'(2)) || ((s_ext + (STEP_W+1)'(2)) >= t_ext);
  assign ramp2    = (s_ext < (STEP_W+1)'(4)) || ((s_ext + (STEP_W+1)'(5)) >= t_ext);
  assign base_sel = ((seq_r == SEQ_UP) || (seq_r == SEQ_DOWN)) ? base_init_r : base_norm_r;

  always_comb begin
    priority if (ramp4) begin
      per = {base_sel, 2'b00};
    end else if (ramp2) begin
      per = {1'b0, base_sel, 1'b0};
    end else begin
      per = {2'b00, base_sel};
    end
  end

  assign q    = per[31:2];
  assign duty = per[31:1];
  assign q2   = {q, 1'b0};
  assign q3   = {2'b00, q} + {1'b0, q2};

  // only the three-quarter offset can overrun the period:
  // 3*floor(p/4) + floor(p/2) > p  <=>  floor(p/4) > ceil((p mod 4)/2)
  assign half_rem  = {1'b0, per[1]} + {1'b0, per[0]};
  assign late_stop = !terminal && (q > 30'(half_rem));

  always_comb begin
    if (dir_r) begin
      ph[0] = '0;
      ph[1] = {2'b00, q};
      ph[2] = {1'b0, q2};
      ph[3] = q3;
    end else begin
      ph[0] = q3;
      ph[1] = {1'b0, q2};
      ph[2] = {2'b00, q};
      ph[3] = '0;
    end
  end

  // --------------------------------------------------------------------------
  // command decode and segment sequencing
  // --------------------------------------------------------------------------
  always_comb begin
    pos_nxt    = pos_r;
    known_nxt  = known_r;
    active_nxt = active_r;
    dir_nxt    = dir_r;
    sidx_nxt   = sidx_r;
    stot_nxt   = stot_r;
    seq_nxt    = seq_r;
    pend_nxt   = pend_r;
    rest_nxt   = rest_r;
    stat_nxt   = STAT_IDLE;
    emit       = 1'b0;
    do_fin     = 1'b0;
    fin_cal    = 1'b0;
    go_ret     = 1'b0;

    priority if (in_cmd_r == CMD_ABORT) begin
      active_nxt = 1'b0;
      known_nxt  = 1'b0;
      stat_nxt   = STAT_ABORTED;
    end else if (active_r || (in_cmd_r == CMD_TICK) || (in_cmd_r > CMD_ABORT)) begin
      // busy commands and unknown codes count as ticks
      if (active_r) begin
        emit     = 1'b1;
        stat_nxt = STAT_STEP;
        sidx_nxt = sidx_r + STEP_W'(1);
        do_fin   = terminal;
      end
    end else if (in_cmd_r == CMD_GOTO) begin
      priority if (!known_r) begin
        stat_nxt = STAT_UNKNOWN;
      end else if ((in_tgt_r < pos_min_r) || (in_tgt_r > pos_max_r)) begin
        stat_nxt = STAT_RANGE;
      end else if (pos_r == in_tgt_r) begin
        stat_nxt = STAT_THERE;
      end else begin
        known_nxt = 1'b0;
        seq_nxt   = SEQ_GOTO;
        pend_nxt  = in_tgt_r;
        if (seg_goto.too_long) begin
          stat_nxt = STAT_RANGE;
        end else begin
          dir_nxt    = seg_goto.dir;
          stot_nxt   = STEP_W'(seg_goto.mag);
          sidx_nxt   = '0;
          active_nxt = 1'b1;
          stat_nxt   = STAT_ACCEPTED;
        end
      end
    end else if (in_cmd_r == CMD_RAW) begin
      known_nxt = 1'b0;
      seq_nxt   = SEQ_RAW;
      priority if (seg_raw.too_long) begin
        stat_nxt = STAT_RANGE;
      end else if (seg_raw.empty) begin
        stat_nxt = STAT_THERE;
      end else begin
        dir_nxt    = seg_raw.dir;
        stot_nxt   = STEP_W'(seg_raw.mag);
        sidx_nxt   = '0;
        active_nxt = 1'b1;
        stat_nxt   = STAT_ACCEPTED;
      end
    end else begin
      // calibrate: sweep up by the span, back down, then return to rest
      rest_nxt  = cal_rest;
      known_nxt = 1'b0;
      seq_nxt   = SEQ_UP;
      if (seg_cal.too_long) begin
        active_nxt = 1'b0;
        stat_nxt   = STAT_RANGE;
      end else begin
        if (seg_cal.empty) begin
          do_fin  = 1'b1;
          fin_cal = 1'b1;
        end else begin
          dir_nxt    = seg_cal.dir;
          stot_nxt   = STEP_W'(seg_cal.mag);
          sidx_nxt   = '0;
          active_nxt = 1'b1;
        end
        stat_nxt = STAT_ACCEPTED;
      end
    end

    // end of segment: advance the sequence, skipping empty segments
    seq_mid = seq_nxt;
    ret_v   = fin_cal ? seg_ret_c : seg_ret_r;
    if (do_fin) begin
      unique case (seq_mid)
        SEQ_GOTO: begin
          pos_nxt    = pend_nxt;
          known_nxt  = 1'b1;
          active_nxt = 1'b0;
        end
        SEQ_UP: begin
          seq_nxt = SEQ_DOWN;
          priority if (seg_dn.too_long) begin
            active_nxt = 1'b0;
          end else if (!seg_dn.empty) begin
            dir_nxt    = seg_dn.dir;
            stot_nxt   = STEP_W'(seg_dn.mag);
            sidx_nxt   = '0;
            active_nxt = 1'b1;
          end else begin
            go_ret = 1'b1;
          end
        end
        SEQ_DOWN: begin
          go_ret = 1'b1;
        end
        SEQ_RET: begin
          pos_nxt    = rest_nxt;
          known_nxt  = 1'b1;
          active_nxt = 1'b0;
        end
        default: begin
          active_nxt = 1'b0;
        end
      endcase

      // bottom of the sweep is taken as pos_max, then return
      if (go_ret) begin
        pos_nxt = pos_max_r;
        seq_nxt = SEQ_RET;
        priority if (ret_v.too_long) begin
          active_nxt = 1'b0;
        end else if (!ret_v.empty) begin
          dir_nxt    = ret_v.dir;
          stot_nxt   = STEP_W'(ret_v.mag);
          sidx_nxt   = '0;
          active_nxt = 1'b1;
        end else begin
          pos_nxt    = rest_nxt;
          known_nxt  = 1'b1;
          active_nxt = 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // result payload
  // --------------------------------------------------------------------------
  logic [31:0] per_nxt, pha_nxt, phb_nxt, phc_nxt, phd_nxt;
  logic [30:0] duty_nxt;
  logic [3:0]  mask_nxt;
  logic        last_nxt;

  // channels 1 and 3 trade places on swapped wiring
  assign per_nxt  = emit ? per : '0;
  assign duty_nxt = emit ? duty : '0;
  assign pha_nxt  = emit ? ph[0] : '0;
  assign phb_nxt  = emit ? (swap_r ? ph[3] : ph[1]) : '0;
  assign phc_nxt  = emit ? ph[2] : '0;
  assign phd_nxt  = emit ? (swap_r ? ph[1] : ph[3]) : '0;
  assign last_nxt = emit && terminal;
  assign mask_nxt = emit ? {late_stop && dir_r && !swap_r,
                            1'b0,
                            late_stop && dir_r && swap_r,
                            late_stop && !dir_r} : '0;

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  logic [2:0]              out_status_r;
  logic [31:0]             out_period_r, out_pha_r, out_phb_r, out_phc_r, out_phd_r;
  logic [30:0]             out_duty_r;
  logic [3:0]              out_mask_r;
  logic                    out_last_r, out_pvalid_r;
  logic signed [POS_W-1:0] out_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_min_r   <= POS_MIN_RST;
      pos_max_r   <= POS_MAX_RST;
      home_r      <= HOME_RST;
      base_init_r <= INIT_BASE_RST;
      base_norm_r <= NORM_BASE_RST;
      swap_r      <= SWAP_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_POS_MIN:  pos_min_r   <= cfg_wdata[POS_W-1:0];
        REG_POS_MAX:  pos_max_r   <= cfg_wdata[POS_W-1:0];
        REG_HOME:     home_r      <= cfg_wdata[POS_W-1:0];
        REG_INIT_PER: base_init_r <= cfg_base;
        REG_NORM_PER: base_norm_r <= cfg_base;
        REG_SWAP:     swap_r      <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      pos_r     <= '0;
      known_r   <= 1'b0;
      active_r  <= 1'b0;
      dir_r     <= 1'b0;
      sidx_r    <= '0;
      stot_r    <= '0;
      seq_r     <= SEQ_RAW;
      pend_r    <= '0;
      rest_r    <= '0;
    end else begin
      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (adv) begin
        in_vld_r <= 1'b0;
      end

      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end

      if (adv) begin
        pos_r    <= pos_nxt;
        known_r  <= known_nxt;
        active_r <= active_nxt;
        dir_r    <= dir_nxt;
        sidx_r   <= sidx_nxt;
        stot_r   <= stot_nxt;
        seq_r    <= seq_nxt;
        pend_r   <= pend_nxt;
        rest_r   <= rest_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_cmd_r <= in_cmd;
      in_tgt_r <= in_target_position;
      in_cnt_r <= in_step_count;
    end
    if (adv) begin
      out_status_r <= stat_nxt;
      out_period_r <= per_nxt;
      out_duty_r   <= duty_nxt;
      out_pha_r    <= pha_nxt;
      out_phb_r    <= phb_nxt;
      out_phc_r    <= phc_nxt;
      out_phd_r    <= phd_nxt;
      out_mask_r   <= mask_nxt;
      out_last_r   <= last_nxt;
      out_pos_r    <= pos_nxt;
      out_pvalid_r <= known_nxt;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_status         = out_status_r;
  assign out_period_ns      = out_period_r;
  assign out_duty_ns        = out_duty_r;
  assign out_phase_a_ns     = out_pha_r;
  assign out_phase_b_ns     = out_phb_r;
  assign out_phase_c_ns     = out_phc_r;
  assign out_phase_d_ns     = out_phd_r;
  assign out_stop_mask      = out_mask_r;
  assign out_last_step      = out_last_r;
  assign out_position_now   = out_pos_r;
  assign out_position_valid = out_pvalid_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // a known position is only ever claimed with the axis at rest
  a_known_at_rest: assert property (@(posedge clk) disable iff (!rst_n)
    known_r |-> !active_r)
    else $error("position known while a move is active");

  // a running segment always has a step left to issue
  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (sidx_r < stot_r))
    else $error("step index ran past segment length");

  // only step results carry a PWM setting
  a_no_pwm_off_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_status_r != STAT_STEP)) |->
      ((out_period_r == '0) && (out_mask_r == '0) && !out_last_r))
    else $error("PWM setting on a non-step result");

endmodule
